### src/blz_pkg.sv
`default_nettype none

package blz_pkg;

    localparam int WINDOW_DEPTH_DEF = 8192;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 24;
    localparam int DIST_W  = 13;
    localparam int LEN_W   = 5;
    localparam int FLAGS_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 24'hFF_FFFF;
    localparam logic [FLAGS_W-1:0] FLAGS_PER  = 4'd8;
    localparam logic [DIST_W-1:0]  DIST_BIAS  = 13'd3;
    localparam logic [LEN_W-1:0]   LEN_BIAS   = 5'd3;
    localparam logic [LEN_W-1:0]   LEN_MAX    = 5'd18;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } blz_state_t;

endpackage

`default_nettype wire

### src/blz_window.sv
`default_nettype none

module blz_window #(
    parameter int WINDOW_DEPTH = blz_pkg::WINDOW_DEPTH_DEF,
    parameter int AW           = $clog2(WINDOW_DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [blz_pkg::BYTE_W-1:0]  wdata,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               raddr,
    output logic      [blz_pkg::BYTE_W-1:0]  rdata
);

    logic [blz_pkg::BYTE_W-1:0] mem [WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/backward_lz_decompressor.sv
`default_nettype none

// Backward LZ77 decompressor.
// Input channel (in_valid/in_stall): compressed bytes, last byte of the buffer
// first; start_of_stream on a byte clears the decoder before that byte.
// Output channel (out_valid/out_stall): decompressed bytes, last byte first,
// with last_of_run on the final byte caused by one input item, finished on
// every byte of the token that used up compressed_count, and bad_distance on
// a byte whose reference reaches before the first produced byte (sent as 0).
// Config channel (cfg_valid/cfg_ready, always ready): compressed_count.
// Flag bytes and first reference bytes give no result. A literal is in the
// output register in the cycle after its accept. A reference of length L (3..18)
// streams one byte per cycle, unless the receiver stalls, through the single read
// port of the window memory; each byte passes the window read register and then
// the output register, and the next input item is taken only once the copy ends.
// Input is stalled during a copy and whenever the output register is full
// and stalled; a stalled receiver freezes the copy in place.
// Reset clears all control state; window contents stay undefined, and bytes read
// from before the first produced byte are sent as 0, so no clearing pass is needed.
module backward_lz_decompressor #(
    parameter int WINDOW_DEPTH = blz_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [blz_pkg::COUNT_W-1:0]  compressed_count,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [blz_pkg::BYTE_W-1:0]   comp_byte,
    input  wire logic                         start_of_stream,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [blz_pkg::BYTE_W-1:0]   out_byte,
    output logic                              last_of_run,
    output logic                              finished,
    output logic                              bad_distance
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int PW = $clog2(WINDOW_DEPTH + 1);

    localparam logic [PW-1:0] PROD_MAX = PW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] WP_LAST  = AW'(WINDOW_DEPTH - 1);

    blz_pkg::blz_state_t state_reg, state_next;

    logic [blz_pkg::COUNT_W-1:0] count_reg;
    logic [blz_pkg::BYTE_W-1:0]  flag_bits_reg, flag_bits_next;
    logic [blz_pkg::FLAGS_W-1:0] flags_left_reg, flags_left_next;
    logic [blz_pkg::BYTE_W-1:0]  held_reg, held_next;
    logic                        holding_reg, holding_next;
    logic [blz_pkg::COUNT_W-1:0] consumed_reg, consumed_next;
    logic [PW-1:0]               produced_reg, produced_next;
    logic [AW-1:0]               wp_reg, wp_next;
    logic                        done_reg, done_next;
    logic [blz_pkg::DIST_W-1:0]  dist_reg, dist_next;
    logic [blz_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic                        fin_reg, fin_next;

    logic                        out_valid_reg, out_valid_next;
    logic [blz_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                        last_reg, last_next;
    logic                        finished_reg, finished_next;
    logic                        bad_reg, bad_next;

    logic                        in_acc;
    logic                        out_free;
    logic                        copy_start;
    logic                        copy_end;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [blz_pkg::BYTE_W-1:0]  wdata;
    logic                        rd_en;
    logic [AW-1:0]               raddr;
    logic [blz_pkg::BYTE_W-1:0]  rdata;

    // e_ : state as seen by this item after an optional stream restart
    logic [blz_pkg::BYTE_W-1:0]  e_flags;
    logic [blz_pkg::FLAGS_W-1:0] e_left;
    logic                        e_holding;
    logic [blz_pkg::COUNT_W-1:0] e_consumed;
    logic [PW-1:0]               e_produced;
    logic [AW-1:0]               e_wp;
    logic                        e_done;
    logic [blz_pkg::COUNT_W-1:0] cons_inc;
    logic                        fin_now;
    logic [blz_pkg::DIST_W-1:0]  ref_dist;
    logic                        copy_bad;

    function automatic logic [AW-1:0] wp_inc(input logic [AW-1:0] p);
        wp_inc = (p == WP_LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [PW-1:0] prod_inc(input logic [PW-1:0] p);
        prod_inc = (p == PROD_MAX) ? p : p + PW'(1);
    endfunction

    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] p,
                                                input logic [blz_pkg::DIST_W-1:0] d);
        logic [AW:0] diff;
        diff = {1'b0, p} - (AW+1)'(d);
        if (diff[AW])
        begin
            diff = diff + (AW+1)'(WINDOW_DEPTH);
        end
        back_addr = diff[AW-1:0];
    endfunction

    blz_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .AW           (AW)
    ) u_window (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .rd_en (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_acc   = in_valid && !in_stall;

    // output logic of the sequencer
    always_comb
    begin
        cfg_ready = 1'b1;
        unique case (state_reg)
            blz_pkg::ST_IDLE: in_stall = !out_free;
            blz_pkg::ST_COPY: in_stall = 1'b1;
            default:          in_stall = 1'b1;
        endcase
    end

    // next state of the sequencer
    always_comb
    begin
        unique case (state_reg)
            blz_pkg::ST_IDLE: state_next = copy_start ? blz_pkg::ST_COPY : blz_pkg::ST_IDLE;
            blz_pkg::ST_COPY: state_next = copy_end ? blz_pkg::ST_IDLE : blz_pkg::ST_COPY;
            default:          state_next = blz_pkg::ST_IDLE;
        endcase
    end

    assign e_flags    = start_of_stream ? '0 : flag_bits_reg;
    assign e_left     = start_of_stream ? '0 : flags_left_reg;
    assign e_holding  = start_of_stream ? 1'b0 : holding_reg;
    assign e_consumed = start_of_stream ? '0 : consumed_reg;
    assign e_produced = start_of_stream ? '0 : produced_reg;
    assign e_wp       = start_of_stream ? '0 : wp_reg;
    assign e_done     = start_of_stream ? 1'b0 : done_reg;
    assign cons_inc   = (e_consumed == blz_pkg::COUNT_MAX) ? e_consumed
                                                            : e_consumed + 24'd1;
    assign fin_now    = cons_inc >= count_reg;
    assign ref_dist   = blz_pkg::DIST_W'({held_reg[3:0], comp_byte}) + blz_pkg::DIST_BIAS;
    assign copy_bad   = PW'(dist_reg) > produced_reg;

    always_comb
    begin
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        held_next       = held_reg;
        holding_next    = holding_reg;
        consumed_next   = consumed_reg;
        produced_next   = produced_reg;
        wp_next         = wp_reg;
        done_next       = done_reg;
        dist_next       = dist_reg;
        rem_next        = rem_reg;
        fin_next        = fin_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        finished_next   = finished_reg;
        bad_next        = bad_reg;
        we              = 1'b0;
        waddr           = wp_reg;
        wdata           = comp_byte;
        rd_en           = 1'b0;
        raddr           = back_addr(wp_reg, dist_reg);
        copy_start      = 1'b0;
        copy_end        = 1'b0;

        if (in_acc)
        begin
            flag_bits_next  = e_flags;
            flags_left_next = e_left;
            holding_next    = e_holding;
            consumed_next   = e_consumed;
            produced_next   = e_produced;
            wp_next         = e_wp;
            done_next       = e_done;
            if (!e_done)
            begin
                consumed_next = cons_inc;
                if (e_left == '0)
                begin
                    flag_bits_next  = comp_byte;
                    flags_left_next = blz_pkg::FLAGS_PER;
                end
                else if (!e_holding && e_flags[7])
                begin
                    held_next    = comp_byte;
                    holding_next = 1'b1;
                end
                else
                begin
                    flag_bits_next  = {e_flags[6:0], 1'b0};
                    flags_left_next = e_left - 4'd1;
                    done_next       = fin_now;
                    if (!e_holding)
                    begin
                        we             = 1'b1;
                        waddr          = e_wp;
                        wp_next        = wp_inc(e_wp);
                        produced_next  = prod_inc(e_produced);
                        out_valid_next = 1'b1;
                        out_byte_next  = comp_byte;
                        last_next      = 1'b1;
                        finished_next  = fin_now;
                        bad_next       = 1'b0;
                    end
                    else
                    begin
                        holding_next = 1'b0;
                        dist_next    = ref_dist;
                        rem_next     = blz_pkg::LEN_W'(held_reg[7:4]) + blz_pkg::LEN_BIAS
                                       - 5'd1;
                        fin_next     = fin_now;
                        rd_en        = 1'b1;
                        raddr        = back_addr(e_wp, ref_dist);
                        copy_start   = 1'b1;
                    end
                end
            end
        end
        else if (state_reg == blz_pkg::ST_COPY && out_free)
        begin
            we             = 1'b1;
            waddr          = wp_reg;
            wdata          = copy_bad ? '0 : rdata;
            wp_next        = wp_inc(wp_reg);
            produced_next  = prod_inc(produced_reg);
            out_valid_next = 1'b1;
            out_byte_next  = copy_bad ? '0 : rdata;
            last_next      = (rem_reg == '0);
            finished_next  = fin_reg;
            bad_next       = copy_bad;
            if (rem_reg == '0)
            begin
                copy_end = 1'b1;
            end
            else
            begin
                rem_next = rem_reg - 5'd1;
                rd_en    = 1'b1;
                raddr    = back_addr(wp_inc(wp_reg), dist_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= blz_pkg::ST_IDLE;
            count_reg      <= '0;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            held_reg       <= '0;
            holding_reg    <= 1'b0;
            consumed_reg   <= '0;
            produced_reg   <= '0;
            wp_reg         <= '0;
            done_reg       <= 1'b0;
            rem_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= compressed_count;
            end
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            held_reg       <= held_next;
            holding_reg    <= holding_next;
            consumed_reg   <= consumed_next;
            produced_reg   <= produced_next;
            wp_reg         <= wp_next;
            done_reg       <= done_next;
            rem_reg        <= rem_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_next;
        fin_reg      <= fin_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        finished_reg <= finished_next;
        bad_reg      <= bad_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_run  = last_reg;
    assign finished     = finished_reg;
    assign bad_distance = bad_reg;

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (we && rd_en) |-> (waddr != raddr))
        else $error("window read and write hit the same entry");

    a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == blz_pkg::ST_COPY) |-> (rem_reg < blz_pkg::LEN_MAX))
        else $error("copy length out of range");

    a_prod_sat: assert property (@(posedge clk) disable iff (!rst_n)
        produced_reg <= PROD_MAX)
        else $error("produced count beyond window depth");

    a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
        copy_end |=> (out_valid && last_of_run && state_reg == blz_pkg::ST_IDLE))
        else $error("copy did not end with a last byte");

endmodule

`default_nettype wire

### tb/backward_lz_decompressor_test.sv
`timescale 1ns / 100ps

module backward_lz_decompressor_test;

    localparam int WIN = blz_pkg::WINDOW_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 300;
    localparam int MAX_DIST = 4098;

    typedef struct packed {
        logic [blz_pkg::BYTE_W-1:0] data;
        logic                       sos;
    } comp_item_t;

    typedef struct packed {
        logic [blz_pkg::BYTE_W-1:0] data;
        logic                       last;
        logic                       fin;
        logic                       bad;
    } out_item_t;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;
    typedef enum int {CNT_EXACT, CNT_EARLY, CNT_MAX, CNT_ZERO} count_mode_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [blz_pkg::COUNT_W-1:0] compressed_count = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [blz_pkg::BYTE_W-1:0]  comp_byte = '0;
    logic                        start_of_stream = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [blz_pkg::BYTE_W-1:0]  out_byte;
    logic                        last_of_run;
    logic                        finished;
    logic                        bad_distance;

    backward_lz_decompressor uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .compressed_count (compressed_count),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .comp_byte        (comp_byte),
        .start_of_stream  (start_of_stream),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .last_of_run      (last_of_run),
        .finished         (finished),
        .bad_distance     (bad_distance)
    );

    comp_item_t comp_queue[$];
    comp_item_t stream_q[$];
    out_item_t  expected_bytes[$];

    int  errors = 0;
    int  cycles = 0;
    int  pushed = 0;
    bit  in_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    comp_item_t next_item;
    out_item_t  seen, want;

    // decoder state mirror
    logic [blz_pkg::BYTE_W-1:0]  window_mem [0:WIN-1];
    logic [blz_pkg::COUNT_W-1:0] count_cfg = '0;
    logic [blz_pkg::BYTE_W-1:0]  flag_bits = '0;
    logic [blz_pkg::FLAGS_W-1:0] flags_left = '0;
    logic [blz_pkg::BYTE_W-1:0]  held_lead = '0;
    logic                        holding = 1'b0;
    logic [blz_pkg::COUNT_W-1:0] consumed = '0;
    int                          produced = 0;
    logic [blz_pkg::DIST_W-1:0]  wr_ptr = '0;
    logic                        done = 1'b0;

    function automatic void put_byte(input logic [blz_pkg::BYTE_W-1:0] v, input logic bad);
        window_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        if (produced < WIN)
            produced++;
        expected_bytes.push_back({v, 1'b0, 1'b0, bad});
    endfunction

    function automatic void copy_byte(input logic [blz_pkg::DIST_W-1:0] back_dist);
        logic [blz_pkg::DIST_W-1:0] idx;
        idx = wr_ptr - back_dist;
        if (int'(back_dist) > produced)
            put_byte('0, 1'b1);
        else
            put_byte(window_mem[idx], 1'b0);
    endfunction

    function automatic void decode_byte(input logic [blz_pkg::BYTE_W-1:0] b, input logic sos);
        logic [blz_pkg::DIST_W-1:0] back_dist;
        logic [blz_pkg::LEN_W-1:0]  len;
        int                         first;
        int                         i;
        if (sos) begin
            flag_bits = '0;
            flags_left = '0;
            held_lead = '0;
            holding = 1'b0;
            consumed = '0;
            produced = 0;
            wr_ptr = '0;
            done = 1'b0;
        end
        if (done)
            return;
        if (consumed < blz_pkg::COUNT_MAX)
            consumed = consumed + 1'b1;
        if (flags_left == 0) begin
            flag_bits = b;
            flags_left = blz_pkg::FLAGS_PER;
            return;
        end
        first = expected_bytes.size();
        if (!holding) begin
            if (flag_bits[7]) begin
                held_lead = b;
                holding = 1'b1;
                return;
            end
            put_byte(b, 1'b0);
        end
        else begin
            back_dist = {1'b0, held_lead[3:0], b} + blz_pkg::DIST_BIAS;
            len = {1'b0, held_lead[7:4]} + blz_pkg::LEN_BIAS;
            for (i = 0; i < len; i++)
                copy_byte(back_dist);
            holding = 1'b0;
        end
        flag_bits = flag_bits << 1;
        flags_left = flags_left - 1'b1;
        if (consumed >= count_cfg)
            done = 1'b1;
        for (i = first; i < expected_bytes.size(); i++)
            expected_bytes[i].fin = done;
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // input driver: bursts with random gaps, payload held while stalled
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (comp_queue.size() > 0) begin
                next_item = comp_queue.pop_front();
                comp_byte <= next_item.data;
                start_of_stream <= next_item.sos;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 80);
        end
        else
            stall_left--;
        case (rx_mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= ~out_stall;
        endcase
    end

    // monitor: check output items, predict on accepted input items
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                seen = {out_byte, last_of_run, finished, bad_distance};
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected item: byte %h last %b fin %b bad %b", $time,
                             out_byte, last_of_run, finished, bad_distance);
                    errors++;
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (seen !== want) begin
                        $display({"%0t: expected byte %h last %b fin %b bad %b, ",
                                  "got byte %h last %b fin %b bad %b"},
                                 $time, want.data, want.last, want.fin, want.bad,
                                 seen.data, seen.last, seen.fin, seen.bad);
                        errors++;
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
                decode_byte(comp_byte, start_of_stream);
        end
    end

    task automatic push_item(input logic [blz_pkg::BYTE_W-1:0] b, input logic sos);
        comp_queue.push_back({b, sos});
        pushed++;
    endtask

    task automatic wait_drained();
        while (comp_queue.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_count(input logic [blz_pkg::COUNT_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        compressed_count <= v;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        count_cfg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stream into stream_q, well-formed unless its tail is dropped, distances mostly inside produced data
    task automatic build_stream(input int ntok);
        logic [blz_pkg::BYTE_W-1:0] flags;
        logic [3:0]                 lnib;
        logic [11:0]                code;
        int                         tok;
        int                         bitn;
        int                         made;
        int                         d;
        stream_q.delete();
        tok = 0;
        made = 0;
        while (tok < ntok) begin
            flags = 8'($urandom_range(0, 255));
            stream_q.push_back({flags, (tok == 0)});
            for (bitn = 7; bitn >= 0 && tok < ntok; bitn--) begin
                if (!flags[bitn]) begin
                    stream_q.push_back({8'($urandom_range(0, 255)), 1'b0});
                    made++;
                end
                else begin
                    case ($urandom_range(0, 4))
                        0:       lnib = 4'hF;
                        1:       lnib = 4'h0;
                        default: lnib = 4'($urandom_range(0, 15));
                    endcase
                    if (made >= 3 && $urandom_range(0, 9) != 0)
                        d = $urandom_range(3, (made > MAX_DIST) ? MAX_DIST : made);
                    else
                        d = $urandom_range(3, MAX_DIST);
                    code = 12'(d - 3);
                    stream_q.push_back({lnib, code[11:8], 1'b0});
                    stream_q.push_back({code[7:0], 1'b0});
                    made += lnib + 3;
                end
                tok++;
            end
        end
        // broken sequence: drop the tail
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, stream_q.size() - 1)) void'(stream_q.pop_back());
    endtask

    task automatic build_noise();
        int n;
        int i;
        stream_q.delete();
        n = $urandom_range(10, 30);
        for (i = 0; i < n; i++)
            stream_q.push_back({8'($urandom_range(0, 255)),
                                (i == 0) || ($urandom_range(0, 9) == 0)});
    endtask

    initial
    begin
        int                          len;
        count_mode_t                 mode;
        logic [blz_pkg::COUNT_W-1:0] cnt;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero count: one token decoded, then further bytes ignored
        write_count('0);
        push_item(8'h00, 1'b1);
        push_item(8'hA5, 1'b0);
        push_item(8'h12, 1'b0);
        push_item(8'hFF, 1'b0);
        wait_drained();

        // full count: literal then references, bad and good distances
        write_count(blz_pkg::COUNT_MAX);
        push_item(8'h7F, 1'b1);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hF0, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h0F, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h10, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h25, 1'b0);
        push_item(8'h5A, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(8'h02, 1'b0);
        // restart in the middle of a reference
        push_item(8'h80, 1'b1);
        push_item(8'h33, 1'b0);
        push_item(8'h01, 1'b1);
        push_item(8'hC3, 1'b0);
        wait_drained();

        while (pushed < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0)
                build_noise();
            else
                build_stream($urandom_range(4, 40));
            len = stream_q.size();
            mode = count_mode_t'($urandom_range(0, 3));
            case (mode)
                CNT_EXACT: cnt = blz_pkg::COUNT_W'(len);
                CNT_EARLY: cnt = blz_pkg::COUNT_W'($urandom_range(0, len));
                CNT_MAX:   cnt = ($urandom_range(0, 1) == 0) ? blz_pkg::COUNT_MAX
                                 : blz_pkg::COUNT_W'($urandom_range(len, 32'hFF_FFFF));
                default:   cnt = ($urandom_range(0, 2) == 0) ? '0 : blz_pkg::COUNT_W'(len);
            endcase
            write_count(cnt);
            while (stream_q.size() > 0) begin
                next_item = stream_q.pop_front();
                push_item(next_item.data, next_item.sos);
            end
            repeat ($urandom_range(0, 3)) push_item(8'($urandom_range(0, 255)), 1'b0);
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
src/blz_pkg.sv
src/blz_window.sv
src/backward_lz_decompressor.sv
tb/backward_lz_decompressor_test.sv
